// ----- hdl/cssw_pkg.sv -----
// cssw_pkg: shared types, constants and command/status structs for the
// waypoint stepper. No dependencies.
package cssw_pkg;

    localparam int COUNT_BITS = 20;
    localparam int INDEX_BITS = COUNT_BITS + 1;
    localparam int STEP_BITS  = 31;
    localparam int SQ_BITS    = 66;   // sum of two 33x33 squares
    localparam int ROOT_BITS  = 34;
    localparam int DIV_BITS   = 35;   // dividend width for the step count
    localparam logic [COUNT_BITS-1:0] STEPS_MAX = '1;

    // register indexes
    localparam logic [1:0] REG_STEP_LENGTH = 2'd0;
    localparam logic [1:0] REG_START_X     = 2'd1;
    localparam logic [1:0] REG_START_Y     = 2'd2;

    // datapath commands, one request at a time
    typedef struct packed {
        logic load_start;   // position <= start, clear leg state
        logic advance;      // index++, add step when in leg
        logic sq_load;      // latch offsets
        logic sq_sum;       // square the two magnitudes
        logic rt_init;      // add the two squares, begin root search
        logic rt_step;      // one root bit
        logic nd_init;      // begin step count division
        logic nd_step;      // one quotient bit
        logic dv_init;      // begin offset divisions
        logic dv_step;      // one quotient bit on both axes
        logic dv_done;      // store steps and deltas
        logic out_load;     // capture result
    } t_cmd;

    typedef struct packed {
        logic step_zero;    // step_length == 0
        logic leg_over;     // next index passes leg_steps
        logic last_bit;     // iteration counter at zero
    } t_sts;

endpackage

// ----- hdl/cssw_datapath.sv -----
// cssw_datapath: position registers, squarer, bitwise root and the
// restoring dividers shared over iterations. Depends on cssw_pkg.
module cssw_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cssw_pkg::t_cmd                    i_cmd,
    output cssw_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [31:0]                       i_cfg_data,
    input  logic [31:0]                       i_target_x,
    input  logic [31:0]                       i_target_y,
    output logic [31:0]                       o_pos_x,
    output logic [31:0]                       o_pos_y,
    output logic [cssw_pkg::COUNT_BITS-1:0]   o_steps,
    output logic [cssw_pkg::INDEX_BITS-1:0]   o_index
);
    localparam int CNT_W = 6;

    logic [cssw_pkg::STEP_BITS-1:0]  r_step_len;
    logic [31:0]                     r_start_x, r_start_y;
    logic [31:0]                     r_pos_x, r_pos_y, r_dlt_x, r_dlt_y;
    logic [cssw_pkg::COUNT_BITS-1:0] r_steps;
    logic [cssw_pkg::INDEX_BITS-1:0] r_index;
    logic [32:0]                     r_dx, r_dy;        // signed offsets
    logic [32:0]                     r_ax, r_ay;        // magnitudes
    logic [65:0]                     r_sqx, r_sqy, r_sum;
    logic [cssw_pkg::ROOT_BITS-1:0]  r_root;
    logic [67:0]                     r_rem;             // root remainder
    logic [CNT_W-1:0]                r_cnt;
    logic [cssw_pkg::DIV_BITS-1:0]   r_nq, r_nr, r_dvsr;
    logic [cssw_pkg::COUNT_BITS-1:0] r_n;
    logic [32:0]                     r_qx, r_qy, r_rx, r_ry;

    logic [cssw_pkg::INDEX_BITS-1:0] n_index;
    logic [67:0]                     n_trial, n_rem_sh;
    logic [cssw_pkg::DIV_BITS:0]     n_nr_sh;
    logic [33:0]                     n_rx_sh, n_ry_sh;
    logic [32:0]                     n_dltx, n_dlty;

    assign n_index = r_index + 1'b1;
    assign o_sts.step_zero = (r_step_len == '0);
    assign o_sts.leg_over  = (n_index > {1'b0, r_steps});
    assign o_sts.last_bit  = (r_cnt == '0);

    // root: two radicand bits per step, restoring digit compare
    assign n_rem_sh = {r_rem[65:0], r_sum[65:64]};
    assign n_trial  = {32'd0, r_root, 2'b01};
    // count division and offset divisions (restoring, one bit a step)
    assign n_nr_sh  = {r_nr, r_nq[cssw_pkg::DIV_BITS-1]};
    assign n_rx_sh  = {r_rx, r_qx[32]};
    assign n_ry_sh  = {r_ry, r_qy[32]};
    assign n_dltx   = r_dx[32] ? (33'd0 - r_qx) : r_qx;
    assign n_dlty   = r_dy[32] ? (33'd0 - r_qy) : r_qy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_len <= cssw_pkg::STEP_BITS'(65536);
            r_start_x  <= '0;
            r_start_y  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cssw_pkg::REG_STEP_LENGTH: r_step_len <= i_cfg_data[30:0];
                cssw_pkg::REG_START_X:     r_start_x  <= i_cfg_data;
                cssw_pkg::REG_START_Y:     r_start_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0; r_pos_y <= '0;
            r_dlt_x <= '0; r_dlt_y <= '0;
            r_steps <= '0; r_index <= '0;
        end else if (i_cmd.load_start) begin
            r_pos_x <= r_start_x; r_pos_y <= r_start_y;
            r_dlt_x <= '0; r_dlt_y <= '0;
            r_steps <= '0; r_index <= '0;
        end else if (i_cmd.advance) begin
            r_index <= n_index;
            if (!o_sts.leg_over) begin
                r_pos_x <= r_pos_x + r_dlt_x;
                r_pos_y <= r_pos_y + r_dlt_y;
            end
        end else if (i_cmd.dv_done) begin
            r_steps <= r_n;
            r_index <= '0;
            if (r_n == '0) begin
                r_dlt_x <= '0; r_dlt_y <= '0;
            end else begin
                r_dlt_x <= n_dltx[31:0]; r_dlt_y <= n_dlty[31:0];
            end
        end
    end

    // leg computation datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_load) begin
            r_dx <= {i_target_x[31], i_target_x} - {r_pos_x[31], r_pos_x};
            r_dy <= {i_target_y[31], i_target_y} - {r_pos_y[31], r_pos_y};
        end
        if (i_cmd.sq_sum) begin
            r_sqx <= 66'(r_ax * r_ax);
            r_sqy <= 66'(r_ay * r_ay);
        end
        if (i_cmd.rt_init) begin
            r_sum  <= r_sqx + r_sqy;
            r_root <= '0;
            r_rem  <= '0;
            r_cnt  <= CNT_W'(32);
        end else if (i_cmd.rt_step) begin
            r_sum <= {r_sum[63:0], 2'b00};
            if (n_rem_sh >= n_trial) begin
                r_rem  <= n_rem_sh - n_trial;
                r_root <= {r_root[cssw_pkg::ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= n_rem_sh;
                r_root <= {r_root[cssw_pkg::ROOT_BITS-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.nd_init) begin
            r_nq   <= {r_root, 1'b0} + cssw_pkg::DIV_BITS'(r_step_len);
            r_nr   <= '0;
            r_dvsr <= {3'd0, r_step_len, 1'b0};
            r_cnt  <= CNT_W'(cssw_pkg::DIV_BITS - 1);
        end else if (i_cmd.nd_step) begin
            if (n_nr_sh >= {1'b0, r_dvsr}) begin
                r_nr <= cssw_pkg::DIV_BITS'(n_nr_sh - {1'b0, r_dvsr});
                r_nq <= {r_nq[cssw_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
                r_nr <= n_nr_sh[cssw_pkg::DIV_BITS-1:0];
                r_nq <= {r_nq[cssw_pkg::DIV_BITS-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.dv_init) begin
            r_n  <= (r_nq > cssw_pkg::DIV_BITS'(cssw_pkg::STEPS_MAX))
                    ? cssw_pkg::STEPS_MAX : r_nq[cssw_pkg::COUNT_BITS-1:0];
            r_qx <= r_ax; r_qy <= r_ay;
            r_rx <= '0;   r_ry <= '0;
            r_cnt <= CNT_W'(32);
        end else if (i_cmd.dv_step) begin
            if (n_rx_sh >= {14'd0, r_n}) begin
                r_rx <= 33'(n_rx_sh - {14'd0, r_n});
                r_qx <= {r_qx[31:0], 1'b1};
            end else begin
                r_rx <= n_rx_sh[32:0];
                r_qx <= {r_qx[31:0], 1'b0};
            end
            if (n_ry_sh >= {14'd0, r_n}) begin
                r_ry <= 33'(n_ry_sh - {14'd0, r_n});
                r_qy <= {r_qy[31:0], 1'b1};
            end else begin
                r_ry <= n_ry_sh[32:0];
                r_qy <= {r_qy[31:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // magnitudes, registered before the squarer
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_sum || i_cmd.sq_load) begin
            r_ax <= r_dx[32] ? (33'd0 - r_dx) : r_dx;
            r_ay <= r_dy[32] ? (33'd0 - r_dy) : r_dy;
        end
    end

    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;
    assign o_steps = r_steps;
    assign o_index = r_index;

endmodule

// ----- hdl/cssw_ctrl.sv -----
// cssw_ctrl: sequencer for start, tick and leg computation.
// Depends on cssw_pkg.
module cssw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_action,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_started,
    output cssw_pkg::t_cmd o_cmd,
    input  cssw_pkg::t_sts i_sts
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_TICK  = 11'b00000000010,
        S_DIFF  = 11'b00000000100,
        S_ABS   = 11'b00000001000,
        S_SQ    = 11'b00000010000,
        S_RINIT = 11'b00000100000,
        S_ROOT  = 11'b00001000000,
        S_NDIV  = 11'b00010000000,
        S_DINIT = 11'b00100000000,
        S_DIV   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_act, r_started, n_started, r_out_valid, r_wait;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_started   = r_started;

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_started = 1'b0;
                    n_state   = S_TICK;
                end
            end
            S_TICK: begin
                if (!r_act) begin
                    o_cmd.load_start = 1'b1;
                    n_state = i_sts.step_zero ? S_OUT : S_DIFF;
                    n_started = !i_sts.step_zero;
                end else if (i_sts.step_zero) begin
                    n_state = S_OUT;
                end else if (i_sts.leg_over) begin
                    n_started = 1'b1;
                    n_state   = S_DIFF;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_DIFF:  begin o_cmd.sq_load = 1'b1; n_state = S_ABS;   end
            S_ABS:   begin o_cmd.sq_sum  = 1'b1; n_state = S_SQ;    end
            // squares taken from the magnitudes latched in S_ABS
            S_SQ:    begin o_cmd.sq_sum  = 1'b1; n_state = S_RINIT; end
            S_RINIT: begin o_cmd.rt_init = 1'b1; n_state = S_ROOT;  end
            S_ROOT: begin
                if (r_wait) begin
                    o_cmd.nd_init = 1'b1;
                    n_state = S_NDIV;
                end else begin
                    o_cmd.rt_step = 1'b1;
                end
            end
            S_NDIV: begin
                o_cmd.nd_step = 1'b1;
                if (i_sts.last_bit) n_state = S_DINIT;
            end
            S_DINIT: begin o_cmd.dv_init = 1'b1; n_state = S_DIV; end
            S_DIV: begin
                if (r_wait) begin
                    o_cmd.dv_done = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.dv_step = 1'b1;
                end
            end
            S_OUT: begin o_cmd.out_load = 1'b1; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    // state, handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_wait      <= 1'b0;
            r_act       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            if (r_state == S_IDLE && i_in_valid && o_in_ready) r_act <= i_action;
            // last iteration flag: counter reached zero on the step just taken
            r_wait <= ((r_state == S_ROOT && o_cmd.rt_step) ||
                       (r_state == S_DIV && o_cmd.dv_step)) && i_sts.last_bit;
            if (o_cmd.out_load)                    r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready)   r_out_valid <= 1'b0;
        end
    end

endmodule

// ----- hdl/constant_speed_waypoint_stepper.sv -----
// constant_speed_waypoint_stepper: top level, joins cssw_ctrl and
// cssw_datapath. Depends on cssw_pkg.
//
// channel   dir  payload
// s_axis    in   tdata {target_y, target_x}, tuser action
// m_axis    out  tdata {step_index, steps_in_leg, position_y, position_x},
//                tuser leg_started
// cfg       in   we / idx / data (step_length, start_x, start_y)
//
// A tick inside a leg passes through S_TICK and S_OUT before its result is valid;
// a leg start runs the 33-step root loop, the 35-step count division and the
// 33-step offset division, with sequencing states between them.
// One request in flight; the next is taken the cycle after the result is taken.
// Reset is synchronous, active low, and loads the reset register values.
module constant_speed_waypoint_stepper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // target_x[31:0], target_y[63:32]
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [111:0] m_axis_tdata,  // pos_x, pos_y, steps_in_leg, step_index, pad
    output logic        m_axis_tuser,   // leg_started
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    cssw_pkg::t_cmd w_cmd;
    cssw_pkg::t_sts w_sts;
    logic [31:0] w_px, w_py;
    logic [cssw_pkg::COUNT_BITS-1:0] w_steps;
    logic [cssw_pkg::INDEX_BITS-1:0] w_idx;
    logic [63:0] r_in;
    logic [104:0] r_res;
    logic w_started;

    // request payload held for the leg computation; result captured on out_load
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_in <= s_axis_tdata;
        if (w_cmd.out_load) r_res <= {w_idx, w_steps, w_py, w_px};
    end

    cssw_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_action(s_axis_tuser),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_started(w_started), .o_cmd(w_cmd), .i_sts(w_sts)
    );

    cssw_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_target_x(r_in[31:0]), .i_target_y(r_in[63:32]),
        .o_pos_x(w_px), .o_pos_y(w_py), .o_steps(w_steps), .o_index(w_idx)
    );

    assign m_axis_tdata = {7'd0, r_res};
    assign m_axis_tuser = w_started;

    // no request taken while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
    // index never passes step count + 1
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_idx <= {1'b0, w_steps} + 1'b1))
        else $error("step index out of range");
    // a started leg reports index zero
    a_leg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_res[104:84] == '0))
        else $error("new leg with nonzero index");

endmodule

// ----- sim/testbench.sv -----
// Testbench for constant_speed_waypoint_stepper: random and directed start/tick
// requests checked against an in-bench motion predictor. Depends on cssw_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // expected result of one request
    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic        started;
        logic [19:0] steps;
        logic [20:0] index;
    } t_motion;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    int errors = 0;

    // predictor plus queue of expected positions
    class t_motion_board;
        logic [30:0] step_len;
        logic [31:0] sx, sy, px, py, dlx, dly;
        logic [19:0] leg_n;
        logic [20:0] leg_i;
        t_motion pending[$];

        function void reset_state();
            step_len = 31'd65536;
            sx = 0; sy = 0; px = 0; py = 0; dlx = 0; dly = 0;
            leg_n = 0; leg_i = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            if (idx == cssw_pkg::REG_STEP_LENGTH) step_len = v[30:0];
            else if (idx == cssw_pkg::REG_START_X) sx = v;
            else if (idx == cssw_pkg::REG_START_Y) sy = v;
        endfunction

        function void aim(logic [31:0] tx, logic [31:0] ty);
            logic signed [33:0] dx, dy;
            logic [65:0] sq;
            logic [67:0] cand2;
            logic [33:0] root, cand;
            logic [35:0] n;
            logic signed [35:0] qx, qy;
            dx = $signed(tx) - $signed(px);
            dy = $signed(ty) - $signed(py);
            sq = 66'(dx * dx) + 66'(dy * dy);
            root = 0;
            for (int b = 33; b >= 0; b--) begin
                cand = root | (34'd1 << b);
                cand2 = 68'(cand) * 68'(cand);
                if (cand2 <= 68'(sq)) root = cand;
            end
            n = (36'(root) * 2 + 36'(step_len)) / (36'(step_len) * 2);
            if (n > 36'(cssw_pkg::STEPS_MAX)) n = 36'(cssw_pkg::STEPS_MAX);
            leg_n = n[19:0];
            if (n == 0) begin
                dlx = 0; dly = 0;
            end else begin
                qx = 36'(dx) / $signed(n);
                qy = 36'(dy) / $signed(n);
                dlx = qx[31:0]; dly = qy[31:0];
            end
            leg_i = 0;
        endfunction

        function void note_request(logic act, logic [31:0] tx, logic [31:0] ty);
            t_motion m;
            m.started = 0;
            if (act == ACT_START) begin
                px = sx; py = sy;
                if (step_len != 0) begin
                    aim(tx, ty); m.started = 1;
                end else begin
                    dlx = 0; dly = 0; leg_n = 0; leg_i = 0;
                end
            end else if (step_len != 0) begin
                leg_i = leg_i + 1;
                if (leg_i <= 21'(leg_n)) begin
                    px = px + dlx; py = py + dly;
                end else begin
                    aim(tx, ty); m.started = 1;
                end
            end
            m.pos_x = px; m.pos_y = py; m.steps = leg_n; m.index = leg_i;
            pending.push_back(m);
        endfunction

        function void check_result(logic [111:0] d, logic u);
            t_motion m;
            if (pending.size() == 0) begin
                $error("unexpected result"); errors++; return;
            end
            m = pending.pop_front();
            if (d[31:0] !== m.pos_x) begin
                $error("position_x exp %h got %h", m.pos_x, d[31:0]); errors++;
            end
            if (d[63:32] !== m.pos_y) begin
                $error("position_y exp %h got %h", m.pos_y, d[63:32]); errors++;
            end
            if (d[83:64] !== m.steps) begin
                $error("steps_in_leg exp %0d got %0d", m.steps, d[83:64]); errors++;
            end
            if (d[104:84] !== m.index) begin
                $error("step_index exp %0d got %0d", m.index, d[104:84]); errors++;
            end
            if (u !== m.started) begin
                $error("leg_started exp %0d got %0d", m.started, u); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic s_axis_tvalid = 0, s_axis_tready, s_axis_tuser = 0;
    logic [63:0] s_axis_tdata = 0;
    logic m_axis_tvalid, m_axis_tready = 0, m_axis_tuser;
    logic [111:0] m_axis_tdata;
    logic i_cfg_we = 0;
    logic [1:0] i_cfg_idx = 0;
    logic [31:0] i_cfg_data = 0;
    bit calm = 0;
    longint cycles = 0;
    t_motion_board board;

    always #4 i_clk = ~i_clk;

    constant_speed_waypoint_stepper dut (.*);

    // timeout guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 2000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: sample, then random back-pressure
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    always @(negedge i_clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 21);

    task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.write_reg(idx, v);
    endtask

    task automatic send(logic act, logic [31:0] tx, logic [31:0] ty);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 21) @(negedge i_clk);
        s_axis_tvalid <= 1; s_axis_tuser <= act; s_axis_tdata <= {ty, tx};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(act, tx, ty);
        @(negedge i_clk);
        s_axis_tvalid <= 0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near(logic [31:0] base, int span);
        return base + 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    // one leg-following run: start, then mostly ticks
    task automatic run_phase(int count, int span);
        send(ACT_START, near(board.sx, span), near(board.sy, span));
        for (int k = 1; k < count; k++) begin
            if ($urandom_range(99) < 3)
                send(ACT_START, $urandom, $urandom);
            else
                send(ACT_TICK, near(board.px, span), near(board.py, span));
        end
    endtask

    initial begin
        board = new();
        board.reset_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, stationary, one-step and zero-step legs
        send(ACT_TICK, 0, 0);
        send(ACT_START, 32'h7fff_ffff, 32'h8000_0000);
        send(ACT_TICK, 0, 0);
        drain();
        cfg_write(cssw_pkg::REG_START_X, 32'h8000_0000);
        cfg_write(cssw_pkg::REG_START_Y, 32'h7fff_ffff);
        cfg_write(cssw_pkg::REG_STEP_LENGTH, 32'h7fff_ffff);
        send(ACT_START, 32'h7fff_ffff, 32'h8000_0000);
        send(ACT_TICK, 32'hffff_ffff, 32'hffff_ffff);
        send(ACT_TICK, 32'h8000_0000, 32'h7fff_ffff);
        send(ACT_TICK, 32'h8000_0000, 32'h7fff_ffff);
        drain();
        cfg_write(cssw_pkg::REG_STEP_LENGTH, 1);
        send(ACT_START, 32'h7fff_ffff, 32'h8000_0000);
        send(ACT_TICK, 0, 0);
        send(ACT_TICK, 0, 0);
        drain();
        cfg_write(cssw_pkg::REG_STEP_LENGTH, 0);
        send(ACT_TICK, 5, 5);
        send(ACT_START, 5, 5);
        send(ACT_TICK, 5, 5);
        drain();
        cfg_write(3, 32'hdead_beef);
        cfg_write(cssw_pkg::REG_STEP_LENGTH, 4);
        cfg_write(cssw_pkg::REG_START_X, 0);
        cfg_write(cssw_pkg::REG_START_Y, 0);
        send(ACT_START, 6, 0);
        send(ACT_TICK, 0, 0);
        send(ACT_TICK, 0, 0);
        send(ACT_TICK, 1, 1);
        send(ACT_TICK, 1, 1);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: cfg_write(cssw_pkg::REG_STEP_LENGTH, $urandom_range(1, 200));
                1: cfg_write(cssw_pkg::REG_STEP_LENGTH, $urandom_range(1, 65536) * 16);
                2: cfg_write(cssw_pkg::REG_STEP_LENGTH, $urandom & 32'h7fff_ffff);
                default: cfg_write(cssw_pkg::REG_STEP_LENGTH,
                                   (ph == 7) ? 0 : 32'h7fff_ffff);
            endcase
            cfg_write(cssw_pkg::REG_START_X, $urandom);
            cfg_write(cssw_pkg::REG_START_Y, $urandom);
            calm = (ph == 5);
            if (ph % 4 == 2 || ph % 4 == 3)
                run_phase(100, 32'h7fff_ffff);
            else
                run_phase(100, board.step_len * $urandom_range(1, 8));
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
